### rtl/core/ttcv_pkg.sv
// shared types and constants for the tilt to cursor velocity block
package ttcv_pkg;

    localparam int ANGLE_W  = 13;
    localparam int CFG_A_W  = 11;
    localparam int SPEED_W  = 7;
    localparam int LIMIT_W  = 8;
    localparam int STEP_W   = 8;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    // dividend is (magnitude - dead zone) * span, 7 by 7 bits
    localparam int DIV_STEPS = 14;
    localparam int DIV_CNT_W = 4;

    localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE_X = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE_Y = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STUCK_LIMIT = 3'd4;

    localparam logic [CFG_A_W-1:0] DEAD_ZONE_RST   = 11'd80;
    localparam logic [CFG_A_W-1:0] MAX_ANGLE_RST   = 11'd720;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 7'd10;
    localparam logic [LIMIT_W-1:0] STUCK_LIMIT_RST = 8'd20;

    typedef struct packed {
        logic [CFG_A_W-1:0] dead_zone;
        logic [CFG_A_W-1:0] max_angle_x;
        logic [CFG_A_W-1:0] max_angle_y;
        logic [SPEED_W-1:0] max_speed;
        logic [LIMIT_W-1:0] stuck_limit;
    } cfg_t;

endpackage

### rtl/core/ttcv_regs.sv
// configuration register file behind the apb-style port
module ttcv_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ttcv_pkg::PADDR_W-1:0]   paddr,
    input  logic [ttcv_pkg::PDATA_W-1:0]   pwdata,
    output logic [ttcv_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output ttcv_pkg::cfg_t                 cfg
);

    ttcv_pkg::cfg_t                   cfg_reg;
    ttcv_pkg::cfg_t                   cfg_next;
    logic                             wr_en;
    logic [ttcv_pkg::REG_IDX_W-1:0]   idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ttcv_pkg::PADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                ttcv_pkg::REG_DEAD_ZONE: begin
                    cfg_next.dead_zone = pwdata[ttcv_pkg::CFG_A_W-1:0];
                end
                ttcv_pkg::REG_MAX_ANGLE_X: begin
                    cfg_next.max_angle_x = pwdata[ttcv_pkg::CFG_A_W-1:0];
                end
                ttcv_pkg::REG_MAX_ANGLE_Y: begin
                    cfg_next.max_angle_y = pwdata[ttcv_pkg::CFG_A_W-1:0];
                end
                ttcv_pkg::REG_MAX_SPEED: begin
                    cfg_next.max_speed = pwdata[ttcv_pkg::SPEED_W-1:0];
                end
                ttcv_pkg::REG_STUCK_LIMIT: begin
                    cfg_next.stuck_limit = pwdata[ttcv_pkg::LIMIT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_zone   <= ttcv_pkg::DEAD_ZONE_RST;
            cfg_reg.max_angle_x <= ttcv_pkg::MAX_ANGLE_RST;
            cfg_reg.max_angle_y <= ttcv_pkg::MAX_ANGLE_RST;
            cfg_reg.max_speed   <= ttcv_pkg::MAX_SPEED_RST;
            cfg_reg.stuck_limit <= ttcv_pkg::STUCK_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            ttcv_pkg::REG_DEAD_ZONE: begin
                prdata = ttcv_pkg::PDATA_W'(cfg_reg.dead_zone);
            end
            ttcv_pkg::REG_MAX_ANGLE_X: begin
                prdata = ttcv_pkg::PDATA_W'(cfg_reg.max_angle_x);
            end
            ttcv_pkg::REG_MAX_ANGLE_Y: begin
                prdata = ttcv_pkg::PDATA_W'(cfg_reg.max_angle_y);
            end
            ttcv_pkg::REG_MAX_SPEED: begin
                prdata = ttcv_pkg::PDATA_W'(cfg_reg.max_speed);
            end
            ttcv_pkg::REG_STUCK_LIMIT: begin
                prdata = ttcv_pkg::PDATA_W'(cfg_reg.stuck_limit);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

### rtl/core/ttcv_axis.sv
// one axis: band classification and a bit-serial restoring divider
module ttcv_axis (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ttcv_pkg::ANGLE_W-1:0] ang,
    input  logic [ttcv_pkg::CFG_A_W-1:0]        max_ang,
    input  logic [ttcv_pkg::CFG_A_W-1:0]        dead_zone,
    input  logic [ttcv_pkg::SPEED_W-1:0]        max_speed,
    output logic                                done,
    output logic [ttcv_pkg::STEP_W-1:0]         step
);

    localparam int DVD_W = 2 * ttcv_pkg::SPEED_W;
    localparam logic [ttcv_pkg::DIV_CNT_W-1:0] LAST_STEP =
        ttcv_pkg::DIV_CNT_W'(ttcv_pkg::DIV_STEPS - 1);

    logic [ttcv_pkg::ANGLE_W-1:0]   mag;
    logic [ttcv_pkg::SPEED_W-1:0]   m_deg;
    logic [ttcv_pkg::SPEED_W-1:0]   dz_deg;
    logic [ttcv_pkg::SPEED_W-1:0]   mx_deg;
    logic [ttcv_pkg::SPEED_W-1:0]   span;
    logic [ttcv_pkg::SPEED_W-1:0]   diff;
    logic [DVD_W-1:0]               product;
    logic                           over_max;
    logic                           over_dz;

    logic [ttcv_pkg::SPEED_W-1:0]   res_fix_reg, res_fix_next;
    logic                           use_div_reg, use_div_next;
    logic                           neg_reg, neg_next;
    logic [ttcv_pkg::SPEED_W-1:0]   divisor_reg, divisor_next;
    logic [ttcv_pkg::SPEED_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]               quo_reg, quo_next;
    logic [ttcv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [ttcv_pkg::SPEED_W:0]     trial;
    logic                           q_bit;
    logic [ttcv_pkg::STEP_W-1:0]    mag_out;

    // magnitude as unsigned, the most negative code maps onto 4096
    assign mag    = ang[ttcv_pkg::ANGLE_W-1] ? ttcv_pkg::ANGLE_W'(0 - ang) : ang;
    assign over_max = mag > {2'b00, max_ang};
    assign over_dz  = mag > {2'b00, dead_zone};
    assign dz_deg = dead_zone[ttcv_pkg::CFG_A_W-1:4];
    assign mx_deg = max_ang[ttcv_pkg::CFG_A_W-1:4];
    // inside the band the integer degree never exceeds mx_deg, so 7 bits hold it
    assign m_deg  = mag[ttcv_pkg::SPEED_W+3:4];
    assign span   = (max_speed != '0) ? max_speed - 1'b1 : '0;
    assign diff   = m_deg - dz_deg;
    assign product = DVD_W'(diff) * DVD_W'(span);

    always_comb begin
        res_fix_next = res_fix_reg;
        use_div_next = use_div_reg;
        neg_next     = neg_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;

        trial = {rem_reg, quo_reg[DVD_W-1]};
        q_bit = trial >= {1'b0, divisor_reg};

        if (start) begin
            divisor_next = mx_deg - dz_deg;
            rem_next     = '0;
            quo_next     = product;
            cnt_next     = '0;
            busy_next    = 1'b1;
            use_div_next = 1'b0;
            neg_next     = 1'b0;
            res_fix_next = '0;
            if (over_max) begin
                res_fix_next = max_speed;
                neg_next     = ~ang[ttcv_pkg::ANGLE_W-1];
            end else if (over_dz) begin
                neg_next = ~ang[ttcv_pkg::ANGLE_W-1];
                if (mx_deg <= dz_deg) begin
                    res_fix_next = max_speed;
                end else begin
                    use_div_next = 1'b1;
                end
            end
        end else if (busy_reg) begin
            rem_next = q_bit ? ttcv_pkg::SPEED_W'(trial - {1'b0, divisor_reg})
                             : trial[ttcv_pkg::SPEED_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_fix_reg <= res_fix_next;
        use_div_reg <= use_div_next;
        neg_reg     <= neg_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    // quotient never exceeds span, so its low 7 bits carry it
    assign mag_out = use_div_reg ? {1'b0, quo_reg[ttcv_pkg::SPEED_W-1:0]} + 8'd1
                                 : {1'b0, res_fix_reg};
    assign step    = neg_reg ? ttcv_pkg::STEP_W'(0 - mag_out) : mag_out;
    assign done    = done_reg;

endmodule

### rtl/core/tilt_to_cursor_velocity.sv
// top level: tilt sample to cursor step, repeat counting and result register
//
//  channel   ports                               direction  handshake
//  sample    s_pitch, s_roll                     in         s_valid / s_ready
//  result    m_step_x, m_step_y, m_send_report,  out        m_valid / m_ready
//            m_reset_sensor
//  config    psel penable pwrite paddr pwdata    in/out     apb-style, pready
//
// a sample runs through the 14 restoring-division steps of the per-axis bit-serial
// divider, then its result is loaded into the result register; both axes run side
// by side, and only one sample is in flight at a time.
// a new sample is accepted once the previous result sits in the result register,
// and a stalled result holds the divider output until that register frees up.
// aresetn is synchronous and active low; registers return to their reset values.
module tilt_to_cursor_velocity (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ttcv_pkg::ANGLE_W-1:0] s_pitch,
    input  logic signed [ttcv_pkg::ANGLE_W-1:0] s_roll,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ttcv_pkg::STEP_W-1:0]  m_step_x,
    output logic signed [ttcv_pkg::STEP_W-1:0]  m_step_y,
    output logic                                m_send_report,
    output logic                                m_reset_sensor,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ttcv_pkg::PADDR_W-1:0]        paddr,
    input  logic [ttcv_pkg::PDATA_W-1:0]        pwdata,
    output logic [ttcv_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    ttcv_pkg::cfg_t                cfg;
    state_t                        state_reg, state_next;
    logic                          accept;
    logic                          done_x;
    logic                          done_y;
    logic [ttcv_pkg::STEP_W-1:0]   step_x;
    logic [ttcv_pkg::STEP_W-1:0]   step_y;
    logic                          slot_free;
    logic                          load;

    logic [ttcv_pkg::ANGLE_W-1:0]  last_pitch_reg, last_pitch_next;
    logic [ttcv_pkg::ANGLE_W-1:0]  last_roll_reg, last_roll_next;
    logic [ttcv_pkg::LIMIT_W-1:0]  repeat_count_reg, repeat_count_next;
    logic                          rst_pend_reg, rst_pend_next;
    logic [ttcv_pkg::LIMIT_W-1:0]  count_inc;

    logic                          m_valid_reg, m_valid_next;
    logic [ttcv_pkg::STEP_W-1:0]   m_step_x_reg, m_step_x_next;
    logic [ttcv_pkg::STEP_W-1:0]   m_step_y_reg, m_step_y_next;
    logic                          m_send_reg, m_send_next;
    logic                          m_rst_reg, m_rst_next;

    ttcv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttcv_axis u_axis_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .ang       (s_pitch),
        .max_ang   (cfg.max_angle_x),
        .dead_zone (cfg.dead_zone),
        .max_speed (cfg.max_speed),
        .done      (done_x),
        .step      (step_x)
    );

    ttcv_axis u_axis_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .ang       (s_roll),
        .max_ang   (cfg.max_angle_y),
        .dead_zone (cfg.dead_zone),
        .max_speed (cfg.max_speed),
        .done      (done_y),
        .step      (step_y)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign slot_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next = state_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // both axes run the same fixed number of steps
                if (done_x & done_y) begin
                    if (slot_free) begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // repeat counting, saturating at the top of the counter
    always_comb begin
        last_pitch_next   = last_pitch_reg;
        last_roll_next    = last_roll_reg;
        repeat_count_next = repeat_count_reg;
        rst_pend_next     = rst_pend_reg;
        count_inc         = '0;
        if (accept) begin
            if ((s_pitch == last_pitch_reg) && (s_roll == last_roll_reg)) begin
                count_inc = (repeat_count_reg == '1) ? repeat_count_reg
                                                     : repeat_count_reg + 1'b1;
            end
            last_pitch_next = s_pitch;
            last_roll_next  = s_roll;
            if ((cfg.stuck_limit != '0) && (count_inc == cfg.stuck_limit)) begin
                rst_pend_next     = 1'b1;
                repeat_count_next = '0;
            end else begin
                rst_pend_next     = 1'b0;
                repeat_count_next = count_inc;
            end
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_step_x_next = m_step_x_reg;
        m_step_y_next = m_step_y_reg;
        m_send_next   = m_send_reg;
        m_rst_next    = m_rst_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            m_step_x_next = step_x;
            m_step_y_next = step_y;
            m_send_next   = (step_x != '0) | (step_y != '0);
            m_rst_next    = rst_pend_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            last_pitch_reg   <= '0;
            last_roll_reg    <= '0;
            repeat_count_reg <= '0;
            rst_pend_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            last_pitch_reg   <= last_pitch_next;
            last_roll_reg    <= last_roll_next;
            repeat_count_reg <= repeat_count_next;
            rst_pend_reg     <= rst_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_step_x_reg <= m_step_x_next;
        m_step_y_reg <= m_step_y_next;
        m_send_reg   <= m_send_next;
        m_rst_reg    <= m_rst_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_step_x       = m_step_x_reg;
    assign m_step_y       = m_step_y_reg;
    assign m_send_report  = m_send_reg;
    assign m_reset_sensor = m_rst_reg;

endmodule

### rtl/core/ttcv_checker.sv
// port-level checks for the tilt to cursor velocity block, bound to the top level
module ttcv_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [ttcv_pkg::STEP_W-1:0]  m_step_x,
    input logic signed [ttcv_pkg::STEP_W-1:0]  m_step_y,
    input logic                                m_send_report,
    input logic                                pready
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transaction");

    a_report_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_send_report == ((m_step_x != 8'sd0) || (m_step_y != 8'sd0))))
        else $error("send_report disagrees with steps");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_step_x != 8'sh80) && (m_step_y != 8'sh80)))
        else $error("step outside symmetric range");

    // one sample at a time: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample accepted while busy");

    a_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("config port stalled");

endmodule

bind tilt_to_cursor_velocity ttcv_checker u_ttcv_checker (.*);

### tb/sv/tb_top.sv
// self-checking testbench for the tilt to cursor velocity block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD     = 8.0;
    localparam int  RESET_CYCLES   = 6;
    localparam int  DRAIN_CYCLES   = 24;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  RANDOM_PHASES  = 7;
    localparam int  PHASE_ITEMS    = 32;
    localparam int  STUCK_RUN      = 258;

    // index with no register behind it, writes there must be ignored
    localparam logic [ttcv_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef struct {
        logic signed [ttcv_pkg::ANGLE_W-1:0] pitch;
        logic signed [ttcv_pkg::ANGLE_W-1:0] roll;
    } tilt_t;

    typedef struct {
        logic signed [ttcv_pkg::STEP_W-1:0] step_x;
        logic signed [ttcv_pkg::STEP_W-1:0] step_y;
        logic                               send_report;
        logic                               reset_sensor;
    } cursor_step_t;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                                aclk    = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [ttcv_pkg::ANGLE_W-1:0] s_pitch = '0;
    logic signed [ttcv_pkg::ANGLE_W-1:0] s_roll  = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [ttcv_pkg::STEP_W-1:0]  m_step_x;
    logic signed [ttcv_pkg::STEP_W-1:0]  m_step_y;
    logic                                m_send_report;
    logic                                m_reset_sensor;
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [ttcv_pkg::PADDR_W-1:0]        paddr   = '0;
    logic [ttcv_pkg::PDATA_W-1:0]        pwdata  = '0;
    logic [ttcv_pkg::PDATA_W-1:0]        prdata;
    logic                                pready;

    tilt_t        tilt_q[$];
    cursor_step_t pending_steps[$];

    // predictor copy of the registers and the repeat tracker
    ttcv_pkg::cfg_t               shadow_cfg;
    logic [ttcv_pkg::ANGLE_W-1:0] seen_pitch = '0;
    logic [ttcv_pkg::ANGLE_W-1:0] seen_roll  = '0;
    int                           repeat_cnt = 0;

    int   n_pushed    = 0;
    int   n_taken     = 0;
    int   n_fail      = 0;
    int   idle_cycles = 0;
    logic in_fire     = 1'b0;

    // sender burst state
    tilt_t drv_item;
    int    burst_left = 0;
    int    gap_left   = 0;

    // receiver state
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       rx_tick   = 0;
    int       hold_left = 0;
    logic     hold_req  = 1'b0;
    logic     hold_done = 1'b0;

    tilt_to_cursor_velocity u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pitch        (s_pitch),
        .s_roll         (s_roll),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_x       (m_step_x),
        .m_step_y       (m_step_y),
        .m_send_report  (m_send_report),
        .m_reset_sensor (m_reset_sensor),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    function automatic logic [ttcv_pkg::STEP_W-1:0] axis_velocity(
            logic signed [ttcv_pkg::ANGLE_W-1:0] ang,
            logic [ttcv_pkg::CFG_A_W-1:0] max_ang);
        int a;
        int dz;
        int mx;
        int mag;
        int m;
        int dzd;
        int mxd;
        int span;
        int speed;
        a     = ang;
        dz    = shadow_cfg.dead_zone;
        mx    = max_ang;
        speed = shadow_cfg.max_speed;
        if (a > mx)
            return ttcv_pkg::STEP_W'(-speed);
        if (a < -mx)
            return ttcv_pkg::STEP_W'(speed);
        if (a > dz || a < -dz) begin
            m    = ((a < 0) ? -a : a) >> 4;
            dzd  = dz >> 4;
            mxd  = mx >> 4;
            span = (speed > 0) ? speed - 1 : 0;
            // integer-degree band can be empty even when the angle band is not
            if (mxd <= dzd)
                mag = speed;
            else
                mag = 1 + ((m - dzd) * span) / (mxd - dzd);
            return (a > 0) ? ttcv_pkg::STEP_W'(-mag) : ttcv_pkg::STEP_W'(mag);
        end
        return '0;
    endfunction

    function automatic cursor_step_t predict_cursor_step(logic [ttcv_pkg::ANGLE_W-1:0] p,
                                                         logic [ttcv_pkg::ANGLE_W-1:0] r);
        cursor_step_t res;
        if (p == seen_pitch && r == seen_roll) begin
            if (repeat_cnt < 255)
                repeat_cnt++;
        end else begin
            repeat_cnt = 0;
        end
        seen_pitch       = p;
        seen_roll        = r;
        res.reset_sensor = 1'b0;
        if (shadow_cfg.stuck_limit != 0 && repeat_cnt == shadow_cfg.stuck_limit) begin
            res.reset_sensor = 1'b1;
            repeat_cnt       = 0;
        end
        res.step_x      = axis_velocity(p, shadow_cfg.max_angle_x);
        res.step_y      = axis_velocity(r, shadow_cfg.max_angle_y);
        res.send_report = (res.step_x != 0) || (res.step_y != 0);
        return res;
    endfunction

    // result check first, then prediction for the sample taken at this edge
    always @(posedge aclk) begin
        cursor_step_t want;
        logic         in_take;
        logic         out_take;
        in_take  = aresetn && s_valid && s_ready;
        out_take = aresetn && m_valid && m_ready;
        if (out_take) begin
            if (pending_steps.size() == 0) begin
                $error("result transaction with no sample pending");
                n_fail++;
            end else begin
                want = pending_steps.pop_front();
                if (m_step_x !== want.step_x) begin
                    $error("step_x expected %0d actual %0d", want.step_x, m_step_x);
                    n_fail++;
                end
                if (m_step_y !== want.step_y) begin
                    $error("step_y expected %0d actual %0d", want.step_y, m_step_y);
                    n_fail++;
                end
                if (m_send_report !== want.send_report) begin
                    $error("send_report expected %0b actual %0b",
                           want.send_report, m_send_report);
                    n_fail++;
                end
                if (m_reset_sensor !== want.reset_sensor) begin
                    $error("reset_sensor expected %0b actual %0b",
                           want.reset_sensor, m_reset_sensor);
                    n_fail++;
                end
            end
        end
        if (in_take) begin
            pending_steps.push_back(predict_cursor_step(s_pitch, s_roll));
            n_taken++;
        end
        in_fire <= in_take;
        if (!aresetn || in_take || out_take)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_fire) begin
            // hold the offered transaction until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (tilt_q.size() > 0) begin
            drv_item = tilt_q.pop_front();
            s_valid <= 1'b1;
            s_pitch <= drv_item.pitch;
            s_roll  <= drv_item.roll;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 20);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: stall pattern switches between modes, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_MOSTLY:   m_ready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: m_ready <= (rx_tick % 4 != 0);
                default:     m_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    task automatic push_tilt(input logic signed [ttcv_pkg::ANGLE_W-1:0] p,
                             input logic signed [ttcv_pkg::ANGLE_W-1:0] r);
        tilt_t t;
        t.pitch = p;
        t.roll  = r;
        tilt_q.push_back(t);
        n_pushed++;
    endtask

    task automatic cfg_write(input logic [ttcv_pkg::REG_IDX_W-1:0] idx,
                             input logic [ttcv_pkg::PDATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            ttcv_pkg::REG_DEAD_ZONE:
                shadow_cfg.dead_zone   = val[ttcv_pkg::CFG_A_W-1:0];
            ttcv_pkg::REG_MAX_ANGLE_X:
                shadow_cfg.max_angle_x = val[ttcv_pkg::CFG_A_W-1:0];
            ttcv_pkg::REG_MAX_ANGLE_Y:
                shadow_cfg.max_angle_y = val[ttcv_pkg::CFG_A_W-1:0];
            ttcv_pkg::REG_MAX_SPEED:
                shadow_cfg.max_speed   = val[ttcv_pkg::SPEED_W-1:0];
            ttcv_pkg::REG_STUCK_LIMIT:
                shadow_cfg.stuck_limit = val[ttcv_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (n_taken != n_pushed || pending_steps.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // low register bits are set, upper bits sometimes carry junk
    function automatic logic [ttcv_pkg::PDATA_W-1:0] with_junk(int val, int width);
        logic [ttcv_pkg::PDATA_W-1:0] w;
        w = val;
        if ($urandom_range(0, 1) == 1)
            w = w | ($urandom << width);
        return w;
    endfunction

    task automatic random_config();
        int dz;
        int ax;
        int ay;
        int speed;
        int lim;
        case ($urandom_range(0, 4))
            0:       dz = 0;
            1:       dz = 2047;
            4:       dz = $urandom_range(0, 2047);
            default: dz = $urandom_range(0, 1440);
        endcase
        case ($urandom_range(0, 5))
            0:       ax = 0;
            1:       ax = 2047;
            2:       ax = (dz + $urandom_range(0, 31)) % 2048;
            default: ax = $urandom_range(0, 1440);
        endcase
        case ($urandom_range(0, 5))
            0:       ay = 0;
            1:       ay = 2047;
            2:       ay = (dz + $urandom_range(0, 31)) % 2048;
            default: ay = $urandom_range(0, 1440);
        endcase
        case ($urandom_range(0, 5))
            0:       speed = 0;
            1:       speed = 127;
            2:       speed = 1;
            default: speed = $urandom_range(1, 127);
        endcase
        case ($urandom_range(0, 7))
            0:       lim = 0;
            1:       lim = 255;
            default: lim = $urandom_range(1, 6);
        endcase
        cfg_write(ttcv_pkg::REG_DEAD_ZONE,   with_junk(dz, ttcv_pkg::CFG_A_W));
        cfg_write(ttcv_pkg::REG_MAX_ANGLE_X, with_junk(ax, ttcv_pkg::CFG_A_W));
        cfg_write(ttcv_pkg::REG_MAX_ANGLE_Y, with_junk(ay, ttcv_pkg::CFG_A_W));
        cfg_write(ttcv_pkg::REG_MAX_SPEED,   with_junk(speed, ttcv_pkg::SPEED_W));
        cfg_write(ttcv_pkg::REG_STUCK_LIMIT, with_junk(lim, ttcv_pkg::LIMIT_W));
    endtask

    // angles cluster around the dead zone and full-speed edges
    function automatic logic signed [ttcv_pkg::ANGLE_W-1:0] rand_angle(int max_ang);
        int                           v;
        logic [ttcv_pkg::PDATA_W-1:0] raw;
        case ($urandom_range(0, 5))
            0:       v = int'(shadow_cfg.dead_zone) + $urandom_range(0, 8) - 4;
            1:       v = max_ang + $urandom_range(0, 8) - 4;
            4:       v = $urandom;
            5:       v = $urandom_range(0, 200) - 100;
            default: v = $urandom_range(0, 5760) - 2880;
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        raw = v;
        return raw[ttcv_pkg::ANGLE_W-1:0];
    endfunction

    // runs of identical samples sized around the stuck limit, with single noise samples
    task automatic random_phase(int n_items);
        int                                  lim;
        int                                  run;
        int                                  k;
        logic signed [ttcv_pkg::ANGLE_W-1:0] p;
        logic signed [ttcv_pkg::ANGLE_W-1:0] r;
        @(posedge aclk);
        lim = shadow_cfg.stuck_limit;
        if (lim == 0 || lim > 8)
            lim = 8;
        k = 0;
        while (k < n_items) begin
            p = rand_angle(shadow_cfg.max_angle_x);
            r = rand_angle(shadow_cfg.max_angle_y);
            if ($urandom_range(0, 3) == 0)
                run = 1;
            else
                run = $urandom_range(1, lim + 1);
            repeat (run) push_tilt(p, r);
            k += run;
        end
    endtask

    initial begin
        shadow_cfg.dead_zone   = ttcv_pkg::DEAD_ZONE_RST;
        shadow_cfg.max_angle_x = ttcv_pkg::MAX_ANGLE_RST;
        shadow_cfg.max_angle_y = ttcv_pkg::MAX_ANGLE_RST;
        shadow_cfg.max_speed   = ttcv_pkg::MAX_SPEED_RST;
        shadow_cfg.stuck_limit = ttcv_pkg::STUCK_LIMIT_RST;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: field extremes and the band edges
        @(posedge aclk);
        push_tilt(0, 0);
        push_tilt(2880, -2880);
        push_tilt(-2880, 2880);
        push_tilt(4095, -4096);
        push_tilt(80, -80);
        push_tilt(81, -81);
        push_tilt(720, -720);
        push_tilt(721, -721);
        push_tilt(96, -400);
        push_tilt(-4096, 4095);
        push_tilt(719, -97);
        wait_idle();

        // no dead zone, widest and narrowest full-speed angle, stuck limit of one repeat
        cfg_write(ttcv_pkg::REG_DEAD_ZONE, 0);
        cfg_write(ttcv_pkg::REG_MAX_ANGLE_X, 2047);
        cfg_write(ttcv_pkg::REG_MAX_ANGLE_Y, 0);
        cfg_write(ttcv_pkg::REG_MAX_SPEED, 127);
        cfg_write(ttcv_pkg::REG_STUCK_LIMIT, 1);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        @(posedge aclk);
        push_tilt(1, 1);
        push_tilt(1, 1);
        push_tilt(-1, -1);
        push_tilt(16, 0);
        push_tilt(2047, -2047);
        push_tilt(2048, 5);
        wait_idle();

        // empty integer-degree band gives saturation, zero speed, stuck limit off
        cfg_write(ttcv_pkg::REG_DEAD_ZONE, 80);
        cfg_write(ttcv_pkg::REG_MAX_ANGLE_X, 90);
        cfg_write(ttcv_pkg::REG_MAX_ANGLE_Y, 90);
        cfg_write(ttcv_pkg::REG_MAX_SPEED, 0);
        cfg_write(ttcv_pkg::REG_STUCK_LIMIT, 0);
        @(posedge aclk);
        push_tilt(85, -85);
        push_tilt(90, -91);
        push_tilt(0, 0);
        push_tilt(100, -100);
        wait_idle();

        // long identical run saturates the repeat count, then the top limit fires at once
        random_config();
        cfg_write(ttcv_pkg::REG_STUCK_LIMIT, 0);
        @(posedge aclk);
        repeat (STUCK_RUN) push_tilt(300, -300);
        wait_idle();
        cfg_write(ttcv_pkg::REG_STUCK_LIMIT, 255);
        @(posedge aclk);
        push_tilt(300, -300);
        push_tilt(300, -300);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config();
            random_phase(PHASE_ITEMS);
            if (ph == 2)
                hold_req <= 1'b1;
            wait_idle();
        end

        if (n_fail == 0 && pending_steps.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ttcv_pkg.sv
rtl/core/ttcv_regs.sv
rtl/core/ttcv_axis.sv
rtl/core/tilt_to_cursor_velocity.sv
rtl/core/ttcv_checker.sv
tb/sv/tb_top.sv
